// ===== hw/rtl/sfche_pkg.sv =====
package sfche_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned HamBytes   = 9;
  localparam int unsigned CntW       = 4;

  localparam logic [7:0] SynChar = 8'd22;
  localparam logic [31:0] CrcPoly = 32'h04C11DB7;

  // Position of each byte in the outgoing frame
  localparam logic [CntW-1:0] IdxSyn0    = 4'd0;
  localparam logic [CntW-1:0] IdxSyn1    = 4'd1;
  localparam logic [CntW-1:0] IdxCount   = 4'd2;
  localparam logic [CntW-1:0] IdxData    = 4'd3;
  localparam logic [CntW-1:0] IdxCrcHi   = 4'd11;
  localparam logic [CntW-1:0] IdxHamLast = 4'd11;
  localparam logic [CntW-1:0] IdxCrcLast = 4'd14;

  typedef enum logic {
    ModeCrc = 1'b0,
    ModeHam = 1'b1
  } code_mode_e;

  // Closed frame handed from the collector to the serializer
  typedef struct packed {
    logic                            valid;
    logic [CntW-1:0]                 count;
    logic [FrameBytes-1:0][7:0]      data;
  } frame_t;

  // Odd parity in bit 7 over bits 6..0
  function automatic logic [7:0] odd_byte(input logic [7:0] b);
    return {~(^b[6:0]), b[6:0]};
  endfunction

  // CRC-32, MSB first, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        top;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      top = c[31] ^ b[i];
      c   = {c[30:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Hamming(71,64) plus overall parity, packed as 9 bytes MSB first.
  // Word bit d fills the d-th non power-of-two position.
  function automatic logic [HamBytes-1:0][7:0] hamming_encode(input logic [63:0] w);
    logic [71:0]               e;
    logic [HamBytes-1:0][7:0]  r;
    logic                      s;
    int                        d;
    e = '0;
    d = 0;
    for (int pos = 1; pos < 72; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        e[pos] = w[d];
        d++;
      end
    end
    for (int p = 0; p < 7; p++) begin
      s = 1'b0;
      for (int pos = 1; pos < 72; pos++) begin
        if (((pos >> p) & 1) != 0) begin
          s = s ^ e[pos];
        end
      end
      e[1 << p] = s;
    end
    e[0] = ^e[71:1];
    for (int i = 0; i < HamBytes; i++) begin
      for (int j = 0; j < 8; j++) begin
        r[i][7-j] = e[i*8+j];
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sfche_collect.sv =====
module sfche_collect (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,  // [7:0] char_byte
  input  logic            s_axis_tlast_i,  // end_of_message
  output sfche_pkg::frame_t frame_o,
  input  logic            take_i
);
  import sfche_pkg::*;

  logic [FrameBytes-1:0][7:0] data_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       full_q, full_d;
  logic                       accept;

  assign s_axis_tready_o = ~full_q;
  assign accept          = s_axis_tvalid_i & ~full_q;

  // Fill count and frame-closed flag
  always_comb begin
    cnt_d  = cnt_q;
    full_d = full_q;
    if (take_i) begin
      cnt_d  = '0;
      full_d = 1'b0;
    end else if (accept) begin
      cnt_d  = cnt_q + 4'd1;
      full_d = s_axis_tlast_i | (cnt_d == CntW'(FrameBytes));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      full_q <= full_d;
    end
  end

  // Character slots, no reset; unused slots are masked on the way out
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q[cnt_q[2:0]] <= s_axis_tdata_i;
    end
  end

  always_comb begin
    frame_o.valid = full_q;
    frame_o.count = cnt_q;
    for (int i = 0; i < FrameBytes; i++) begin
      frame_o.data[i] = (CntW'(i) < cnt_q) ? data_q[i] : 8'h00;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FrameBytes))
    else $error("fill count above frame size");
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> cnt_q != '0)
    else $error("closed frame without characters");
`endif

endmodule

// ===== hw/rtl/sfche_serial.sv =====
module sfche_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  sfche_pkg::frame_t frame_i,
  output logic              take_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,  // [7:0] out_byte
  output logic              m_axis_tlast_o   // frame_last
);
  import sfche_pkg::*;

  code_mode_e                 mode_q;
  logic                       busy_q;
  logic [CntW-1:0]            idx_q;
  logic [CntW-1:0]            cnt_q;
  logic [FrameBytes-1:0][7:0] word_q;
  logic [HamBytes-1:0][7:0]   ham_q;
  logic [31:0]                crc_q;
  logic                       valid_q;
  logic [7:0]                 tdata_q;
  logic                       tlast_q;

  logic [FrameBytes-1:0][7:0] word_d;
  logic [63:0]                word_flat;
  logic                       adv;
  logic                       last;
  logic [CntW-1:0]            sel;
  logic [7:0]                 byte_d;
  logic                       in_data;

  assign take_o = ~busy_q & frame_i.valid;
  assign adv    = busy_q & (~valid_q | m_axis_tready_i);
  assign sel    = idx_q - IdxData;

  // Parity-coded data word, byte 0 on top
  always_comb begin
    for (int i = 0; i < FrameBytes; i++) begin
      word_d[i]                = odd_byte(frame_i.data[i]);
      word_flat[63-8*i -: 8]   = word_d[i];
    end
  end

  // Pick the byte for the current frame position
  always_comb begin
    in_data = 1'b0;
    last    = 1'b0;
    case (idx_q)
      IdxSyn0, IdxSyn1: byte_d = odd_byte(SynChar);
      IdxCount:         byte_d = odd_byte({4'h0, cnt_q});
      default: begin
        if (mode_q == ModeCrc) begin
          last = (idx_q == IdxCrcLast);
          if (idx_q < IdxCrcHi) begin
            in_data = 1'b1;
            byte_d  = word_q[sel[2:0]];
          end else begin
            case (sel[1:0])
              2'd0:    byte_d = crc_q[31:24];
              2'd1:    byte_d = crc_q[23:16];
              2'd2:    byte_d = crc_q[15:8];
              default: byte_d = crc_q[7:0];
            endcase
          end
        end else begin
          last   = (idx_q == IdxHamLast);
          byte_d = (sel < CntW'(HamBytes)) ? ham_q[sel] : 8'h00;
        end
      end
    endcase
  end

  // Config register, frame position and output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeCrc;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= code_mode_e'(cfg_data_i);
      end
      if (take_o) begin
        busy_q <= 1'b1;
        idx_q  <= IdxSyn0;
      end else if (adv) begin
        idx_q <= idx_q + 4'd1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Frame payload, CRC accumulator and output data
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      cnt_q  <= frame_i.count;
      word_q <= word_d;
      ham_q  <= hamming_encode(word_flat);
      crc_q  <= '0;
    end else if (adv && in_data) begin
      crc_q <= crc_byte(crc_q, byte_d);
    end
    if (adv) begin
      tdata_q <= byte_d;
      tlast_q <= last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tlast_o  = tlast_q;

`ifndef SYNTHESIS
  a_idx_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && mode_q == ModeCrc) |-> idx_q <= IdxCrcLast)
    else $error("frame position past CRC frame end");
  a_idx_ham: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && mode_q == ModeHam) |-> idx_q <= IdxHamLast)
    else $error("frame position past Hamming frame end");
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> busy_q && idx_q == IdxSyn0)
    else $error("frame load did not start emission");
`endif

endmodule

// ===== hw/rtl/sync_frame_crc_hamming_encoder.sv =====
// Channel   Dir  Data                               Side info
// s_axis    in   tdata[7:0] char_byte               tlast end_of_message
// m_axis    out  tdata[7:0] out_byte                tlast frame_last
// cfg       in   cfg_data_i code_mode (0 CRC, 1 Hamming)
//
// Input beats are taken one per cycle into an 8-slot buffer until a frame closes.
// A closed frame moves to the serializer once it is idle; the buffer then refills
// while the serializer emits 15 (CRC) or 12 (Hamming) beats, one per cycle unless
// m_axis stalls. Sustained rate is set by the output, plus a hand-over per frame.
// Reset clears counts, flags and code_mode; no clearing pass is needed.
// Stalls on m_axis hold the output beat and back up into s_axis.
module sync_frame_crc_hamming_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] char_byte
  input  logic       s_axis_tlast_i,  // end_of_message
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o,  // frame_last
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);
  import sfche_pkg::*;

  frame_t frame;
  logic   take;

  assign cfg_ready_o = 1'b1;

  sfche_collect u_collect (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .frame_o         (frame),
    .take_i          (take)
  );

  sfche_serial u_serial (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .frame_i         (frame),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== verif/sync_frame_crc_hamming_encoder_tb.sv =====
module sync_frame_crc_hamming_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfche_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned PhaseItems  = 13;

  // One transmitted byte as seen on m_axis
  typedef struct {
    logic [7:0] tx_byte;
    logic       last;
  } tx_beat_t;

  // Collects message characters, builds each closed frame and holds the
  // bytes still owed by the block.
  class frame_tracker;
    logic [7:0]   char_buf [FrameBytes];
    int unsigned  fill;
    code_mode_e   mode;
    tx_beat_t     tx_due [$];
    int unsigned  errors;
    int unsigned  chars_seen;
    int unsigned  crc_frames;
    int unsigned  ham_frames;
    int unsigned  beats_ok;

    function new();
      foreach (char_buf[i]) char_buf[i] = '0;
      fill       = 0;
      mode       = ModeCrc;
      errors     = 0;
      chars_seen = 0;
      crc_frames = 0;
      ham_frames = 0;
      beats_ok   = 0;
    endfunction

    function void set_mode(code_mode_e m);
      mode = m;
    endfunction

    function int unsigned pending();
      return tx_due.size();
    endfunction

    // Bit 7 becomes odd parity over the low seven bits
    function logic [7:0] with_parity(logic [7:0] b);
      logic [7:0] r;
      r    = b;
      r[7] = 1'b1;
      for (int i = 0; i < 7; i++) r[7] = r[7] ^ b[i];
      return r;
    endfunction

    function void owe(logic [7:0] b);
      tx_beat_t t;
      t.tx_byte = b;
      t.last    = 1'b0;
      tx_due.push_back(t);
    endfunction

    // Header, then either data plus CRC-32 or the 72-bit SECDED codeword
    function void build_frame();
      logic [63:0] word;
      logic [71:0] cw;
      logic [31:0] crc;
      logic [7:0]  b;
      logic        fb;
      int          d;
      word = '0;
      for (int i = 0; i < FrameBytes; i++) word = {word[55:0], with_parity(char_buf[i])};
      owe(with_parity(SynChar));
      owe(with_parity(SynChar));
      owe(with_parity(8'(fill)));
      if (mode == ModeCrc) begin
        crc = '0;
        for (int i = 63; i >= 0; i--) begin
          fb  = crc[31] ^ word[i];
          crc = {crc[30:0], 1'b0} ^ (fb ? CrcPoly : 32'h0);
        end
        for (int i = 0; i < FrameBytes; i++) owe(word[63 - 8*i -: 8]);
        for (int i = 0; i < 4; i++) owe(crc[31 - 8*i -: 8]);
        crc_frames++;
      end else begin
        cw = '0;
        d  = 0;
        for (int pos = 1; pos < 72; pos++) begin
          if ((pos & (pos - 1)) != 0) begin
            cw[pos] = word[d];
            d++;
          end
        end
        // check bits cover the data positions with their bit set
        for (int p = 0; p < 7; p++) begin
          fb = 1'b0;
          for (int pos = 3; pos < 72; pos++) begin
            if (((pos & (pos - 1)) != 0) && pos[p]) fb = fb ^ cw[pos];
          end
          cw[1 << p] = fb;
        end
        cw[0] = ^cw[71:1];
        for (int i = 0; i < HamBytes; i++) begin
          for (int j = 0; j < 8; j++) b[7-j] = cw[8*i + j];
          owe(b);
        end
        ham_frames++;
      end
      tx_due[tx_due.size() - 1].last = 1'b1;
      foreach (char_buf[i]) char_buf[i] = '0;
      fill = 0;
    endfunction

    // Accepted input beat
    function void note_char(logic [7:0] ch, logic eom);
      chars_seen++;
      if (fill < FrameBytes) begin
        char_buf[fill] = ch;
        fill++;
      end
      if (fill >= FrameBytes || eom) build_frame();
    endfunction

    task flag(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Accepted output beat against the oldest owed byte
    task check_beat(logic [7:0] got_byte, logic got_last);
      tx_beat_t want;
      if (tx_due.size() == 0) begin
        flag($sformatf("unexpected beat tdata=%02h tlast=%0b", got_byte, got_last));
      end else begin
        want = tx_due.pop_front();
        if (got_byte !== want.tx_byte)
          flag($sformatf("tdata %02h, want %02h", got_byte, want.tx_byte));
        else if (got_last !== want.last)
          flag($sformatf("tlast %0b, want %0b (tdata %02h)", got_last, want.last, got_byte));
        else
          beats_ok++;
      end
    endtask
  endclass

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = '0;  // [7:0] char_byte
  logic       s_axis_tlast_i  = 1'b0;  // end_of_message
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;  // [7:0] out_byte
  logic       m_axis_tlast_o;  // frame_last
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i      = 1'b0;

  int unsigned  idle_pct  = 0;
  int unsigned  stall_pct = 0;
  int unsigned  cycles    = 0;
  frame_tracker tx_model  = new();

  sync_frame_crc_hamming_encoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d bytes still owed", cycles, tx_model.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: sample the handshake mid-cycle, check it after the edge
  initial begin : rx_side
    logic [7:0] got_byte;
    logic       got_last;
    logic       took;
    forever begin
      @(negedge clk_i);
      took     = m_axis_tvalid_o && m_axis_tready_i && rst_ni;
      got_byte = m_axis_tdata_o;
      got_last = m_axis_tlast_o;
      @(posedge clk_i);
      if (took) tx_model.check_beat(got_byte, got_last);
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One character beat; called and returns at a rising edge
  task automatic send_char(input logic [7:0] ch, input logic eom);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= eom;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    tx_model.note_char(ch, eom);
  endtask

  // Mode write; only issued while the block is idle
  task automatic write_mode(input code_mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tx_model.set_mode(m);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tx_model.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random messages of 1..20 characters, eom on the last one
  task automatic random_messages(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(3))
        0:       len = 8;
        1:       len = 16;
        default: len = $urandom_range(20, 1);
      endcase
      for (int unsigned i = 0; i < len; i++)
        send_char(8'($urandom_range(255)), i == len - 1);
      sent += len;
    end
  endtask

  initial begin : stimulus
    logic [7:0] corner_chars [8];
    code_mode_e phase_mode;
    corner_chars = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h16, 8'hAA, 8'h55, 8'h01};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, CRC: full frame without eom, one-byte frame, short frame
    write_mode(ModeCrc);
    foreach (corner_chars[i]) send_char(corner_chars[i], 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h7F, 1'b1);
    drain();

    // Directed, Hamming: eom on the eighth byte, one-byte frame, short frame
    write_mode(ModeHam);
    foreach (corner_chars[i]) send_char(corner_chars[i], i == 7);
    send_char(8'h00, 1'b1);
    for (int i = 7; i >= 3; i--) send_char(corner_chars[i], i == 3);
    drain();

    // Random phases over all idling mixes, both modes each
    for (int ph = 0; ph < 8; ph++) begin
      phase_mode = (ph % 2 == 0) ? ModeHam : ModeCrc;
      case (ph / 2)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 60; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      write_mode(phase_mode);
      random_messages(PhaseItems);
      drain();
    end

    $display("Sent %0d characters: %0d CRC frames and %0d Hamming frames under four idling mixes",
             tx_model.chars_seen, tx_model.crc_frames, tx_model.ham_frames);
    $display("Output beats matched: %0d, mismatches: %0d", tx_model.beats_ok, tx_model.errors);
    if (tx_model.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
